[hw/rtl/ssd_pkg.sv]
// Shared types, constants and glyph functions for the seven-segment display driver.
// Used by seven_segment_two_wire_display_driver_core; depends on nothing else.
`default_nettype none

package ssd_pkg;

    localparam int DIGITS   = 4;
    localparam int STORE_AW = $clog2(DIGITS);

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_RAW    = 2'd1,
        ACT_ASCII  = 2'd2,
        ACT_NUMBER = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        FR_CMD  = 2'd0,
        FR_ADDR = 2'd1,
        FR_CTRL = 2'd2
    } frame_t;

    typedef enum logic [1:0] {
        PART_START = 2'd0,
        PART_BYTES = 2'd1,
        PART_STOP  = 2'd2
    } part_t;

    localparam logic [7:0] CMD_DATA  = 8'h40;
    localparam logic [7:0] CMD_ADDR  = 8'hC0;
    localparam logic [7:0] CMD_CTRL  = 8'h88;
    localparam logic [7:0] GLYPH_DASH = 8'h40;
    localparam logic [7:0] SEG_DOT   = 8'h80;
    localparam logic [2:0] BRIGHT_RESET = 3'd4;

    localparam logic signed [15:0] NUM_MAX = 16'sd9999;
    localparam logic signed [15:0] NUM_MIN = -16'sd999;

    function automatic logic [7:0] glyph_digit(input logic [3:0] d);
        logic [7:0] g;
        case (d)
            4'd0:    g = 8'h3F;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5B;
            4'd3:    g = 8'h4F;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6D;
            4'd6:    g = 8'h7D;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7F;
            4'd9:    g = 8'h6F;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] glyph_char(input logic [7:0] c_in);
        logic [7:0] c;
        logic [7:0] g;
        c = c_in;
        if (c >= 8'h61 && c <= 8'h7A) begin
            c = c - 8'd32;
        end
        case (c)
            8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
            8'h35, 8'h36, 8'h37, 8'h38, 8'h39: g = glyph_digit(4'(c - 8'h30));
            8'h41:   g = 8'h77;  // A
            8'h42:   g = 8'h7C;  // B
            8'h43:   g = 8'h39;  // C
            8'h44:   g = 8'h5E;  // D
            8'h45:   g = 8'h79;  // E
            8'h46:   g = 8'h71;  // F
            8'h47:   g = 8'h3D;  // G
            8'h48:   g = 8'h76;  // H
            8'h49:   g = 8'h06;  // I
            8'h4A:   g = 8'h1E;  // J
            8'h4C:   g = 8'h38;  // L
            8'h4E:   g = 8'h37;  // N
            8'h4F:   g = 8'h3F;  // O
            8'h50:   g = 8'h73;  // P
            8'h51:   g = 8'h67;  // Q
            8'h52:   g = 8'h50;  // R
            8'h53:   g = 8'h6D;  // S
            8'h54:   g = 8'h78;  // T
            8'h55:   g = 8'h3E;  // U
            8'h59:   g = 8'h6E;  // Y
            8'h5A:   g = 8'h5B;  // Z
            8'h2D:   g = 8'h40;  // minus
            8'h5F:   g = 8'h08;  // underscore
            default: g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/seven_segment_two_wire_display_driver_core.sv]
// Top level of the four-digit seven-segment display driver with a two-wire line.
// Holds the handshake stages, segment store, slot sequencer and number converter.
// Depends on ssd_pkg.
`default_nettype none

// An accepted transaction passes from the input register to the result register.
// Throughput: one transaction per cycle while results are drained, set by the
// single-pass sequencer step between those registers; a stalled result holds the input.
// A number load passes through converter stages n0, n1 and n2 before writing the segment
// store, still well before the address frame reads it.
// Reset (aresetn low, synchronous): store blank, sequencer idle, data released, brightness 4.

module seven_segment_two_wire_display_driver_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [7:0]  s_byte0,
    input  wire logic [7:0]  s_byte1,
    input  wire logic [7:0]  s_byte2,
    input  wire logic [7:0]  s_byte3,
    input  wire logic signed [15:0] s_number,
    input  wire logic [3:0]  s_dot_mask,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_clock_line,
    output logic             m_data_line,
    output logic             m_busy_res,
    output logic             m_rejected
);

    // ------------------------------------------------------------------
    // Handshake stages. The input register holds one accepted transaction;
    // it is processed when the result register is empty or being drained,
    // so a new transaction enters every cycle while results keep flowing.
    // ------------------------------------------------------------------
    logic                in_valid_reg;
    ssd_pkg::action_t    in_action_reg;
    logic [7:0]          in_byte_reg [ssd_pkg::DIGITS];
    logic signed [15:0]  in_number_reg;
    logic [3:0]          in_mask_reg;

    logic out_valid_reg;
    logic out_clk_reg;
    logic out_dat_reg;
    logic out_busy_reg;
    logic out_rej_reg;

    logic proc;
    logic in_take;

    assign proc    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc;
    assign in_take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_take) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_action_reg  <= ssd_pkg::action_t'(s_action);
            in_byte_reg[0] <= s_byte0;
            in_byte_reg[1] <= s_byte1;
            in_byte_reg[2] <= s_byte2;
            in_byte_reg[3] <= s_byte3;
            in_number_reg  <= s_number;
            in_mask_reg    <= s_dot_mask;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state. Rather than one flat slot counter, the position in
    // the 207-slot sequence is tracked as frame, part (start, bytes, stop),
    // phase within a three-slot group, bit within a byte (8 is the
    // acknowledge group) and byte within the frame. Every position then
    // decodes with a few compares.
    // ------------------------------------------------------------------
    logic             sending_reg,   sending_next;
    ssd_pkg::frame_t  frame_reg,     frame_next;
    ssd_pkg::part_t   part_reg,      part_next;
    logic [1:0]       ph_reg,        ph_next;
    logic [3:0]       bit_reg,       bit_next;
    logic [2:0]       byte_reg,      byte_next;
    logic             data_hold_reg, data_hold_next;
    // Clock level of the last emitted slot; 1 before the first slot.
    logic             last_clk_reg,  last_clk_next;
    logic [2:0]       brightness_reg;
    logic [7:0]       store_reg [ssd_pkg::DIGITS];

    // Levels of the slot at the current position.
    logic [7:0]                  cur_byte;
    logic [ssd_pkg::STORE_AW-1:0] store_idx;
    logic [2:0]                  last_byte;
    logic                        emit_clk;
    logic                        emit_dat;

    assign store_idx = ssd_pkg::STORE_AW'(byte_reg - 3'd1);
    assign last_byte = (frame_reg == ssd_pkg::FR_ADDR) ? 3'(ssd_pkg::DIGITS) : 3'd0;

    always_comb begin
        case (frame_reg)
            ssd_pkg::FR_CMD:  cur_byte = ssd_pkg::CMD_DATA;
            ssd_pkg::FR_ADDR: cur_byte = (byte_reg == 3'd0) ? ssd_pkg::CMD_ADDR
                                                            : store_reg[store_idx];
            ssd_pkg::FR_CTRL: cur_byte = ssd_pkg::CMD_CTRL | {5'd0, brightness_reg};
            default:          cur_byte = ssd_pkg::CMD_DATA;
        endcase
    end

    always_comb begin
        case (part_reg)
            ssd_pkg::PART_START: begin
                // Start condition: data falls while the clock is high.
                emit_clk = (ph_reg != 2'd2);
                emit_dat = (ph_reg == 2'd0);
            end
            ssd_pkg::PART_BYTES: begin
                if (bit_reg < 4'd8) begin
                    // Clock low with the old level, set the bit, then clock high.
                    emit_clk = (ph_reg == 2'd2);
                    emit_dat = (ph_reg == 2'd0) ? data_hold_reg : cur_byte[bit_reg[2:0]];
                end else begin
                    // Acknowledge slot: the line is released and not sampled.
                    emit_clk = (ph_reg == 2'd1);
                    emit_dat = 1'b1;
                end
            end
            ssd_pkg::PART_STOP: begin
                // Stop condition: data rises while the clock is high.
                emit_clk = (ph_reg != 2'd0);
                emit_dat = (ph_reg == 2'd2);
            end
            default: begin
                emit_clk = 1'b1;
                emit_dat = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // One step of the model for the transaction in the input register.
    // ------------------------------------------------------------------
    logic       is_tick;
    logic       load_ok;
    logic       res_clk;
    logic       res_dat;
    logic       res_rej;
    logic [7:0] ascii_seg [ssd_pkg::DIGITS];
    logic       ascii_end;

    assign is_tick = (in_action_reg == ssd_pkg::ACT_TICK);
    assign load_ok = proc && !is_tick && !sending_reg;

    // A zero character blanks its own position and every position after it.
    always_comb begin
        ascii_end = 1'b0;
        for (int i = 0; i < ssd_pkg::DIGITS; i++) begin
            if (in_byte_reg[i] == 8'h00) begin
                ascii_end = 1'b1;
            end
            ascii_seg[i] = ascii_end ? 8'h00 : ssd_pkg::glyph_char(in_byte_reg[i]);
        end
    end

    always_comb begin
        sending_next   = sending_reg;
        frame_next     = frame_reg;
        part_next      = part_reg;
        ph_next        = ph_reg;
        bit_next       = bit_reg;
        byte_next      = byte_reg;
        data_hold_next = data_hold_reg;
        last_clk_next  = last_clk_reg;
        res_clk        = sending_reg ? last_clk_reg : 1'b1;
        res_dat        = data_hold_reg;
        res_rej        = 1'b0;

        if (proc) begin
            if (is_tick) begin
                if (sending_reg) begin
                    res_clk        = emit_clk;
                    res_dat        = emit_dat;
                    data_hold_next = emit_dat;
                    last_clk_next  = emit_clk;
                    ph_next        = ph_reg + 2'd1;
                    if (ph_reg == 2'd2) begin
                        ph_next = 2'd0;
                        case (part_reg)
                            ssd_pkg::PART_START: begin
                                part_next = ssd_pkg::PART_BYTES;
                                bit_next  = 4'd0;
                                byte_next = 3'd0;
                            end
                            ssd_pkg::PART_BYTES: begin
                                bit_next = bit_reg + 4'd1;
                                if (bit_reg == 4'd8) begin
                                    bit_next  = 4'd0;
                                    byte_next = byte_reg + 3'd1;
                                    if (byte_reg == last_byte) begin
                                        part_next = ssd_pkg::PART_STOP;
                                    end
                                end
                            end
                            ssd_pkg::PART_STOP: begin
                                part_next = ssd_pkg::PART_START;
                                if (frame_reg == ssd_pkg::FR_CTRL) begin
                                    frame_next   = ssd_pkg::FR_CMD;
                                    sending_next = 1'b0;
                                end else begin
                                    frame_next = ssd_pkg::frame_t'(frame_reg + 2'd1);
                                end
                            end
                            default: begin
                                part_next = ssd_pkg::PART_START;
                            end
                        endcase
                    end
                end
            end else if (sending_reg) begin
                res_rej = 1'b1;
            end else begin
                // Accepted load: start a fresh sequence.
                sending_next  = 1'b1;
                frame_next    = ssd_pkg::FR_CMD;
                part_next     = ssd_pkg::PART_START;
                ph_next       = 2'd0;
                bit_next      = 4'd0;
                byte_next     = 3'd0;
                last_clk_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sending_reg   <= 1'b0;
            frame_reg     <= ssd_pkg::FR_CMD;
            part_reg      <= ssd_pkg::PART_START;
            ph_reg        <= 2'd0;
            bit_reg       <= 4'd0;
            byte_reg      <= 3'd0;
            data_hold_reg <= 1'b1;
            last_clk_reg  <= 1'b1;
        end else begin
            sending_reg   <= sending_next;
            frame_reg     <= frame_next;
            part_reg      <= part_next;
            ph_reg        <= ph_next;
            bit_reg       <= bit_next;
            byte_reg      <= byte_next;
            data_hold_reg <= data_hold_next;
            last_clk_reg  <= last_clk_next;
        end
    end

    // The control frame reads the level at the tick that sends each bit, so a write
    // takes effect on the bits that go out after it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= ssd_pkg::BRIGHT_RESET;
        end else if (cfg_we) begin
            brightness_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Number converter. The clamped magnitude is split into decimal digits
    // over three registered stages, n0, n1 and n2, each followed by a row of
    // parallel compares against multiples of the place value: thousands from
    // n0, hundreds from n1, tens and units from n2. The store is written from
    // the last stage, at least 61 ticks ahead of its first read.
    // ------------------------------------------------------------------
    logic signed [15:0] num_clamped;
    logic               num_neg;
    logic [13:0]        num_mag;

    always_comb begin
        num_clamped = in_number_reg;
        if (in_number_reg > ssd_pkg::NUM_MAX) begin
            num_clamped = ssd_pkg::NUM_MAX;
        end else if (in_number_reg < ssd_pkg::NUM_MIN) begin
            num_clamped = ssd_pkg::NUM_MIN;
        end
        num_neg = num_clamped[15];
        num_mag = num_neg ? 14'(-num_clamped) : 14'(num_clamped);
    end

    logic        n0_valid_reg;
    logic [13:0] n0_mag_reg;
    logic        n0_neg_reg;
    logic [3:0]  n0_mask_reg;

    logic        n1_valid_reg;
    logic [3:0]  n1_th_reg;
    logic [9:0]  n1_rem_reg;
    logic        n1_neg_reg;
    logic [3:0]  n1_mask_reg;

    logic        n2_valid_reg;
    logic [3:0]  n2_th_reg;
    logic [3:0]  n2_hu_reg;
    logic [6:0]  n2_rem_reg;
    logic        n2_neg_reg;
    logic [3:0]  n2_mask_reg;

    logic [3:0]  th_dig;
    logic [13:0] th_sub;
    logic [3:0]  hu_dig;
    logic [9:0]  hu_sub;
    logic [3:0]  te_dig;
    logic [6:0]  te_sub;
    logic [3:0]  un_dig;

    always_comb begin
        th_dig = 4'd0;
        th_sub = 14'd0;
        for (int k = 1; k < 10; k++) begin
            if (n0_mag_reg >= 14'(k * 1000)) begin
                th_dig = 4'(k);
                th_sub = 14'(k * 1000);
            end
        end
    end

    always_comb begin
        hu_dig = 4'd0;
        hu_sub = 10'd0;
        for (int k = 1; k < 10; k++) begin
            if (n1_rem_reg >= 10'(k * 100)) begin
                hu_dig = 4'(k);
                hu_sub = 10'(k * 100);
            end
        end
    end

    always_comb begin
        te_dig = 4'd0;
        te_sub = 7'd0;
        for (int k = 1; k < 10; k++) begin
            if (n2_rem_reg >= 7'(k * 10)) begin
                te_dig = 4'(k);
                te_sub = 7'(k * 10);
            end
        end
        un_dig = 4'(n2_rem_reg - te_sub);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n0_valid_reg <= 1'b0;
            n1_valid_reg <= 1'b0;
            n2_valid_reg <= 1'b0;
        end else begin
            n0_valid_reg <= load_ok && (in_action_reg == ssd_pkg::ACT_NUMBER);
            n1_valid_reg <= n0_valid_reg;
            n2_valid_reg <= n1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        n0_mag_reg  <= num_mag;
        n0_neg_reg  <= num_neg;
        n0_mask_reg <= in_mask_reg;

        n1_th_reg   <= th_dig;
        n1_rem_reg  <= 10'(n0_mag_reg - th_sub);
        n1_neg_reg  <= n0_neg_reg;
        n1_mask_reg <= n0_mask_reg;

        n2_th_reg   <= n1_th_reg;
        n2_hu_reg   <= hu_dig;
        n2_rem_reg  <= 7'(n1_rem_reg - hu_sub);
        n2_neg_reg  <= n1_neg_reg;
        n2_mask_reg <= n1_mask_reg;
    end

    // Segment store: raw and character loads write at their step, number
    // loads from the converter's last stage. The two never overlap because
    // a second load is rejected for the whole sequence.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ssd_pkg::DIGITS; i++) begin
                store_reg[i] <= 8'h00;
            end
        end else if (load_ok && in_action_reg == ssd_pkg::ACT_RAW) begin
            for (int i = 0; i < ssd_pkg::DIGITS; i++) begin
                store_reg[i] <= in_byte_reg[i];
            end
        end else if (load_ok && in_action_reg == ssd_pkg::ACT_ASCII) begin
            for (int i = 0; i < ssd_pkg::DIGITS; i++) begin
                store_reg[i] <= ascii_seg[i];
            end
        end else if (n2_valid_reg) begin
            store_reg[0] <= (n2_neg_reg ? ssd_pkg::GLYPH_DASH : ssd_pkg::glyph_digit(n2_th_reg))
                            | (n2_mask_reg[0] ? ssd_pkg::SEG_DOT : 8'h00);
            store_reg[1] <= ssd_pkg::glyph_digit(n2_hu_reg)
                            | (n2_mask_reg[1] ? ssd_pkg::SEG_DOT : 8'h00);
            store_reg[2] <= ssd_pkg::glyph_digit(te_dig)
                            | (n2_mask_reg[2] ? ssd_pkg::SEG_DOT : 8'h00);
            store_reg[3] <= ssd_pkg::glyph_digit(un_dig)
                            | (n2_mask_reg[3] ? ssd_pkg::SEG_DOT : 8'h00);
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            out_clk_reg  <= res_clk;
            out_dat_reg  <= res_dat;
            out_busy_reg <= sending_next;
            out_rej_reg  <= res_rej;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_clock_line = out_clk_reg;
    assign m_data_line  = out_dat_reg;
    assign m_busy_res   = out_busy_reg;
    assign m_rejected   = out_rej_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A rejected load can only happen mid-sequence, and it leaves the sequence running.
    a_rej_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rejected) |-> m_busy_res)
        else $error("rejected result without busy");

    // While idle the sequencer rests at the start of the first frame.
    a_idle_home: assert property (@(posedge aclk) disable iff (!aresetn)
        !sending_reg |-> (frame_reg == ssd_pkg::FR_CMD && part_reg == ssd_pkg::PART_START
                          && ph_reg == 2'd0))
        else $error("sequencer position not cleared while idle");

    // The number converter only runs inside a sequence that it started.
    a_num_in_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (n0_valid_reg || n1_valid_reg || n2_valid_reg) |-> sending_reg)
        else $error("number conversion outside a sequence");

    // While bytes go out, the byte counter never runs past the address frame's last
    // store byte.
    a_byte_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (part_reg == ssd_pkg::PART_BYTES) |-> (byte_reg <= 3'(ssd_pkg::DIGITS)))
        else $error("byte counter out of range");

endmodule

`default_nettype wire
